// File: rtl/core/lfbu_pkg.sv
// ----------------------------------------------------------------------------
// lfbu_pkg
// Shared types, codes and tables for the LPC frame bit unpacker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfbu_pkg;

  localparam int MAX_PHRASE_BYTES_DEF = 255;
  localparam int MAX_RES              = 4;
  localparam int RES_IDX_W            = $clog2(MAX_RES);
  localparam int RES_CNT_W            = $clog2(MAX_RES + 1);
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [3:0] STOP_ENERGY   = 4'd15;
  localparam logic [5:0] SILENT_ENERGY = 6'h00;

  localparam logic [3:0] FIELD_ENERGY = 4'd0;
  localparam logic [3:0] FIELD_REPEAT = 4'd1;
  localparam logic [3:0] FIELD_PITCH  = 4'd2;
  localparam logic [3:0] FIELD_K4     = 4'd6;
  localparam logic [3:0] FIELD_K10    = 4'd12;

  localparam logic [2:0] FTYPE_SILENT   = 3'd0;
  localparam logic [2:0] FTYPE_REPEAT   = 3'd1;
  localparam logic [2:0] FTYPE_UNVOICED = 3'd2;
  localparam logic [2:0] FTYPE_VOICED   = 3'd3;
  localparam logic [2:0] FTYPE_STOP     = 3'd4;

  localparam logic KIND_FIELD   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic STATUS_STOP_FOUND = 1'b0;
  localparam logic STATUS_NO_STOP    = 1'b1;

  typedef struct packed {
    logic [7:0] after;
    logic       status;
    logic [2:0] ftype;
    logic       fend;
    logic [5:0] val;
    logic [3:0] idx;
    logic       kind;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]   cnt;
    res_t [MAX_RES-1:0]     res;
  } rec_t;

  function automatic logic [2:0] field_width(input logic [3:0] pos);
    logic [2:0] w;
    unique case (pos)
      4'd1:                  w = 3'd1;
      4'd2:                  w = 3'd6;
      4'd3, 4'd4:            w = 3'd5;
      4'd10, 4'd11, 4'd12:   w = 3'd3;
      default:               w = 3'd4;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lpc_frame_bit_unpacker_unit.sv
// ----------------------------------------------------------------------------
// lpc_frame_bit_unpacker_unit
// Unpacks LPC speech bytes into frame fields and phrase-end summaries.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                         Meaning
// in_      in   tvalid tready tdata[7:0] tlast  speech byte, tlast = last byte
// out_     out  tvalid tready tdata[23:0]       decoded field or summary
//                tuser tlast                    tuser = kind, tlast = last result
//
// The front decodes a whole byte in its accepting cycle and queues its results.
// The back sends one result per cycle unless out_tready stalls it; a byte with
// no result is accepted by the front but queues no record.
// Synchronous active-low reset returns to the start of a phrase, queue empty.
// Two queued records and the output register absorb stalls on out_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_frame_bit_unpacker_unit #(
  parameter int MAX_PHRASE_BYTES = lfbu_pkg::MAX_PHRASE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // speech_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // field_index[3:0], field_value[9:4], frame_end[10], frame_type[13:11],
  // phrase_status[14], bytes_after_stop[22:15], zero[23]
  output logic [23:0]      out_tdata,
  output logic             out_tuser,  // result_kind
  output logic             out_tlast
);

  logic           q_full;
  logic           q_push;
  lfbu_pkg::rec_t q_rec;
  logic           q_pop;
  logic           q_valid;
  lfbu_pkg::rec_t q_head;
  lfbu_pkg::res_t res;

  lfbu_front #(
    .MAX_PHRASE_BYTES(MAX_PHRASE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .speech_byte(in_tdata),
    .last_byte  (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (q_rec)
  );

  lfbu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (q_rec),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_rec  (q_head)
  );

  lfbu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_valid),
    .head_rec  (q_head),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, res.after, res.status, res.ftype, res.fend, res.val, res.idx};
  assign out_tuser = res.kind;

  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("record pushed into a full queue");

  a_head_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (q_head.cnt != '0))
    else $error("queued record holds no result");

  a_summary_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == lfbu_pkg::KIND_SUMMARY)) |-> out_tlast)
    else $error("summary result is not the last of its byte");

  a_ftype_fend : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[10]) |-> (out_tdata[13:11] == lfbu_pkg::FTYPE_SILENT))
    else $error("frame type set on a field that does not end a frame");

endmodule

`default_nettype wire

// File: rtl/core/lfbu_front.sv
// ----------------------------------------------------------------------------
// lfbu_front
// Accepts speech bytes, walks their bits and builds one record of results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfbu_front #(
  parameter int MAX_PHRASE_BYTES = lfbu_pkg::MAX_PHRASE_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    speech_byte,
  input  wire logic          last_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output lfbu_pkg::rec_t     q_rec
);

  logic [3:0] pos_r, pos_nxt;
  logic [5:0] acc_r, acc_nxt;
  logic [2:0] taken_r, taken_nxt;
  logic       rep_r, rep_nxt;
  logic       pz_r, pz_nxt;
  logic       stop_r, stop_nxt;
  logic [7:0] trail_r, trail_nxt;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [7:0]                      sb;
    logic [3:0]                      nxt;
    logic                            fend;
    logic [2:0]                      ftype;
    logic [lfbu_pkg::RES_CNT_W-1:0]  n;
    lfbu_pkg::rec_t                  rec;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    taken_nxt = taken_r;
    rep_nxt   = rep_r;
    pz_nxt    = pz_r;
    stop_nxt  = stop_r;
    trail_nxt = trail_r;
    sb        = speech_byte;
    n         = '0;
    rec       = '0;
    nxt       = '0;
    fend      = 1'b0;
    ftype     = lfbu_pkg::FTYPE_SILENT;
    if (stop_r && (trail_r < 8'(MAX_PHRASE_BYTES))) begin
      trail_nxt = trail_r + 8'd1;
    end
    for (int b = 0; b < 8; b++) begin
      if (!stop_nxt) begin
        if (pos_nxt > lfbu_pkg::FIELD_K10) begin
          pos_nxt = lfbu_pkg::FIELD_ENERGY;
        end
        acc_nxt   = {acc_nxt[4:0], sb[7]};
        taken_nxt = taken_nxt + 3'd1;
        if (taken_nxt >= lfbu_pkg::field_width(pos_nxt)) begin
          nxt   = pos_nxt + 4'd1;
          fend  = 1'b0;
          ftype = lfbu_pkg::FTYPE_SILENT;
          unique case (pos_nxt)
            lfbu_pkg::FIELD_ENERGY: begin
              if (acc_nxt == {2'b00, lfbu_pkg::STOP_ENERGY}) begin
                fend     = 1'b1;
                ftype    = lfbu_pkg::FTYPE_STOP;
                nxt      = lfbu_pkg::FIELD_ENERGY;
                stop_nxt = 1'b1;
              end else if (acc_nxt == lfbu_pkg::SILENT_ENERGY) begin
                fend  = 1'b1;
                ftype = lfbu_pkg::FTYPE_SILENT;
                nxt   = lfbu_pkg::FIELD_ENERGY;
              end
            end
            lfbu_pkg::FIELD_REPEAT: begin
              rep_nxt = acc_nxt[0];
            end
            lfbu_pkg::FIELD_PITCH: begin
              pz_nxt = (acc_nxt == 6'd0);
              if (rep_nxt) begin
                fend  = 1'b1;
                ftype = lfbu_pkg::FTYPE_REPEAT;
                nxt   = lfbu_pkg::FIELD_ENERGY;
              end
            end
            lfbu_pkg::FIELD_K4: begin
              if (pz_nxt) begin
                fend  = 1'b1;
                ftype = lfbu_pkg::FTYPE_UNVOICED;
                nxt   = lfbu_pkg::FIELD_ENERGY;
              end
            end
            lfbu_pkg::FIELD_K10: begin
              fend  = 1'b1;
              ftype = lfbu_pkg::FTYPE_VOICED;
              nxt   = lfbu_pkg::FIELD_ENERGY;
            end
            default: begin
            end
          endcase
          if (n < lfbu_pkg::RES_CNT_W'(lfbu_pkg::MAX_RES)) begin
            rec.res[n[lfbu_pkg::RES_IDX_W-1:0]] = '{
              kind:   lfbu_pkg::KIND_FIELD,
              idx:    pos_nxt,
              val:    acc_nxt,
              fend:   fend,
              ftype:  ftype,
              status: lfbu_pkg::STATUS_STOP_FOUND,
              after:  8'd0
            };
            n = n + 1'b1;
          end
          pos_nxt   = nxt;
          acc_nxt   = 6'd0;
          taken_nxt = 3'd0;
        end
      end
      sb = {sb[6:0], 1'b0};
    end
    if (last_byte) begin
      if (n < lfbu_pkg::RES_CNT_W'(lfbu_pkg::MAX_RES)) begin
        rec.res[n[lfbu_pkg::RES_IDX_W-1:0]] = '{
          kind:   lfbu_pkg::KIND_SUMMARY,
          idx:    4'd0,
          val:    6'd0,
          fend:   1'b0,
          ftype:  lfbu_pkg::FTYPE_SILENT,
          status: stop_nxt ? lfbu_pkg::STATUS_STOP_FOUND : lfbu_pkg::STATUS_NO_STOP,
          after:  stop_nxt ? trail_nxt : 8'd0
        };
        n = n + 1'b1;
      end
      pos_nxt   = lfbu_pkg::FIELD_ENERGY;
      acc_nxt   = 6'd0;
      taken_nxt = 3'd0;
      rep_nxt   = 1'b0;
      pz_nxt    = 1'b0;
      stop_nxt  = 1'b0;
      trail_nxt = 8'd0;
    end
    rec.cnt = n;
    q_rec   = rec;
    q_push  = accept && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= lfbu_pkg::FIELD_ENERGY;
      acc_r   <= 6'd0;
      taken_r <= 3'd0;
      rep_r   <= 1'b0;
      pz_r    <= 1'b0;
      stop_r  <= 1'b0;
      trail_r <= 8'd0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      taken_r <= taken_nxt;
      rep_r   <= rep_nxt;
      pz_r    <= pz_nxt;
      stop_r  <= stop_nxt;
      trail_r <= trail_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lfbu_queue.sv
// ----------------------------------------------------------------------------
// lfbu_queue
// Short first-in first-out queue of result records between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfbu_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire lfbu_pkg::rec_t  push_rec,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output lfbu_pkg::rec_t       head_rec
);

  localparam int PtrW = (lfbu_pkg::QUEUE_DEPTH > 1) ? $clog2(lfbu_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(lfbu_pkg::QUEUE_DEPTH + 1);

  lfbu_pkg::rec_t mem_r [lfbu_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (cnt_r == CntW'(lfbu_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(lfbu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(lfbu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lfbu_back.sv
// ----------------------------------------------------------------------------
// lfbu_back
// Plays out the results of each queued record, one per cycle unless out_ready
// stalls it, into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfbu_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire lfbu_pkg::rec_t  head_rec,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lfbu_pkg::res_t       out_res,
  output logic                 out_last
);

  logic [lfbu_pkg::RES_IDX_W-1:0] sel_r, sel_nxt;
  logic                           valid_r, valid_nxt;
  lfbu_pkg::res_t                 res_r;
  logic                           last_r;
  logic                           load;
  logic                           sel_last;

  assign load     = (!valid_r || out_ready) && head_valid;
  assign sel_last = ({1'b0, sel_r} == (head_rec.cnt - 1'b1));
  assign pop      = load && sel_last;

  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      sel_nxt   = sel_last ? '0 : sel_r + 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= head_rec.res[sel_r];
      last_r <= sel_last;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

// File: test/tb_lpc_frame_bit_unpacker_unit.sv
// ----------------------------------------------------------------------------
// tb_lpc_frame_bit_unpacker_unit
// Self-checking testbench for the LPC frame bit unpacker. A short table of
// directed bytes comes first, then random phrases built from well-formed
// frames, truncated phrases and noise. Every accepted byte is run through a
// local bit-serial decoder, and each result transaction is compared field by
// field with the oldest expected result. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lpc_frame_bit_unpacker_unit;

  localparam int RANDOM_ITEMS = 120;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int TRAILER_RUN  = 260;

  localparam logic [3:0] FIELD_K1 = lfbu_pkg::FIELD_PITCH + 4'd1;
  localparam logic [2:0] SLOT_WIDTH [13] = '{3'd4, 3'd1, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4,
                                             3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3};

  typedef enum int {FRAME_SILENT, FRAME_REPEAT, FRAME_UNVOICED, FRAME_VOICED} frame_kind_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] idx;
    logic [5:0] val;
    logic       fend;
    logic [2:0] ftype;
    logic       status;
    logic [7:0] after_stop;
    logic       lastr;
  } lpc_result_t;

  typedef struct packed {
    logic [7:0]             b;
    logic                   final_byte;
    logic                   typed;
    logic [2:0]             n;
    lpc_result_t [3:0]      res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  lpc_frame_bit_unpacker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Decoder state.
  logic [3:0]  slot;
  logic [5:0]  acc;
  logic [2:0]  taken;
  logic        repeat_flag;
  logic        unvoiced_flag;
  logic        stopped;
  logic [7:0]  trailer_count;

  lpc_result_t step_out [4];
  int          step_count;
  lpc_result_t expected_results [$];
  stim_row_t   stim_table [$];
  bit          phrase_bits [$];

  int mismatches;
  int results_checked;
  int frame_ends;
  int summaries;
  int bytes_sent;
  int phrases_sent;
  int counted_items;
  int idle_cycles;
  int steady_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic lpc_result_t fld(logic [3:0] idx, logic [5:0] val, logic fend,
                                      logic [2:0] ftype);
    lpc_result_t r;
    r = '0;
    r.kind  = lfbu_pkg::KIND_FIELD;
    r.idx   = idx;
    r.val   = val;
    r.fend  = fend;
    r.ftype = ftype;
    return r;
  endfunction

  function automatic lpc_result_t summ(logic status, logic [7:0] after_stop);
    lpc_result_t r;
    r = '0;
    r.kind       = lfbu_pkg::KIND_SUMMARY;
    r.status     = status;
    r.after_stop = after_stop;
    return r;
  endfunction

  task automatic clear_state();
    slot          = lfbu_pkg::FIELD_ENERGY;
    acc           = '0;
    taken         = '0;
    repeat_flag   = 1'b0;
    unvoiced_flag = 1'b0;
    stopped       = 1'b0;
    trailer_count = '0;
  endtask

  task automatic add_result(input lpc_result_t r);
    if (step_count < lfbu_pkg::MAX_RES) begin
      step_out[step_count] = r;
      step_count++;
    end
  endtask

  // Reads the byte most significant bit first and collects its results.
  task automatic decode_byte(input logic [7:0] b, input logic final_byte);
    logic [3:0] p;
    logic [3:0] nxt;
    logic       fend;
    logic [2:0] ftype;
    step_count = 0;
    if (stopped && trailer_count < 8'(lfbu_pkg::MAX_PHRASE_BYTES_DEF))
      trailer_count++;
    for (int k = 7; k >= 0; k--) begin
      if (!stopped) begin
        p     = (slot > lfbu_pkg::FIELD_K10) ? lfbu_pkg::FIELD_ENERGY : slot;
        acc   = {acc[4:0], b[k]};
        taken = taken + 3'd1;
        if (taken < SLOT_WIDTH[p]) begin
          slot = p;
        end else begin
          nxt   = p + 4'd1;
          fend  = 1'b0;
          ftype = lfbu_pkg::FTYPE_SILENT;
          if (p == lfbu_pkg::FIELD_ENERGY) begin
            if (acc == {2'b00, lfbu_pkg::STOP_ENERGY}) begin
              fend    = 1'b1;
              ftype   = lfbu_pkg::FTYPE_STOP;
              nxt     = lfbu_pkg::FIELD_ENERGY;
              stopped = 1'b1;
            end else if (acc == lfbu_pkg::SILENT_ENERGY) begin
              fend  = 1'b1;
              ftype = lfbu_pkg::FTYPE_SILENT;
              nxt   = lfbu_pkg::FIELD_ENERGY;
            end
          end else if (p == lfbu_pkg::FIELD_REPEAT) begin
            repeat_flag = acc[0];
          end else if (p == lfbu_pkg::FIELD_PITCH) begin
            unvoiced_flag = (acc == 6'd0);
            if (repeat_flag) begin
              fend  = 1'b1;
              ftype = lfbu_pkg::FTYPE_REPEAT;
              nxt   = lfbu_pkg::FIELD_ENERGY;
            end
          end else if (p == lfbu_pkg::FIELD_K4) begin
            if (unvoiced_flag) begin
              fend  = 1'b1;
              ftype = lfbu_pkg::FTYPE_UNVOICED;
              nxt   = lfbu_pkg::FIELD_ENERGY;
            end
          end else if (p == lfbu_pkg::FIELD_K10) begin
            fend  = 1'b1;
            ftype = lfbu_pkg::FTYPE_VOICED;
            nxt   = lfbu_pkg::FIELD_ENERGY;
          end
          add_result(fld(p, acc, fend, ftype));
          slot  = nxt;
          acc   = '0;
          taken = '0;
        end
      end
    end
    if (final_byte) begin
      if (stopped)
        add_result(summ(lfbu_pkg::STATUS_STOP_FOUND, trailer_count));
      else
        add_result(summ(lfbu_pkg::STATUS_NO_STOP, 8'd0));
      clear_state();
    end
    if (step_count > 0)
      step_out[step_count-1].lastr = 1'b1;
  endtask

  function automatic stim_row_t plain_row(logic [7:0] b, logic final_byte);
    stim_row_t row;
    row            = '0;
    row.b          = b;
    row.final_byte = final_byte;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] b, logic final_byte, int n,
                                          lpc_result_t r0, lpc_result_t r1,
                                          lpc_result_t r2, lpc_result_t r3);
    stim_row_t row;
    row        = plain_row(b, final_byte);
    row.typed  = 1'b1;
    row.n      = 3'(n);
    row.res[0] = r0;
    row.res[1] = r1;
    row.res[2] = r2;
    row.res[3] = r3;
    if (n > 0)
      row.res[n-1].lastr = 1'b1;
    return row;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      steady_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input stim_row_t row);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= row.b;
    in_tlast  <= row.final_byte;
    do @(posedge clk); while (!in_tready);
    decode_byte(row.b, row.final_byte);
    if (row.typed) begin
      for (int i = 0; i < int'(row.n); i++)
        expected_results.push_back(row.res[i]);
    end else begin
      for (int i = 0; i < step_count; i++)
        expected_results.push_back(step_out[i]);
    end
    bytes_sent++;
    if (row.final_byte)
      phrases_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic add_bits(input int value, input int width);
    for (int i = width - 1; i >= 0; i--)
      phrase_bits.push_back(value[i]);
  endtask

  task automatic add_frame(input frame_kind_t fk);
    if (fk == FRAME_SILENT) begin
      add_bits(lfbu_pkg::SILENT_ENERGY, 4);
      return;
    end
    add_bits($urandom_range(1, 14), 4);
    add_bits(fk == FRAME_REPEAT, 1);
    if (fk == FRAME_REPEAT)
      add_bits($urandom_range(0, 63), 6);
    else if (fk == FRAME_UNVOICED)
      add_bits(0, 6);
    else
      add_bits($urandom_range(1, 63), 6);
    if (fk == FRAME_REPEAT)
      return;
    for (int k = FIELD_K1;
         k <= ((fk == FRAME_VOICED) ? lfbu_pkg::FIELD_K10 : lfbu_pkg::FIELD_K4); k++)
      add_bits($urandom_range(0, (1 << SLOT_WIDTH[k]) - 1), SLOT_WIDTH[k]);
  endtask

  // Sends the queued bits as bytes, padded with random bits, then any trailers.
  task automatic send_phrase(input int trailers);
    logic [7:0] b;
    int         total;
    while (phrase_bits.size() % 8 != 0)
      phrase_bits.push_back($urandom_range(0, 1));
    total = phrase_bits.size() / 8 + trailers;
    for (int i = 0; i < total; i++) begin
      if (phrase_bits.size() > 0) begin
        for (int k = 7; k >= 0; k--)
          b[k] = phrase_bits.pop_front();
      end else begin
        b = 8'($urandom());
      end
      send_byte(plain_row(b, i == total - 1));
    end
  endtask

  task automatic random_phrase();
    int r;
    int frames;
    int keep;
    int n;
    r = $urandom_range(0, 99);
    phrase_bits.delete();
    if (r < 10) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_byte(plain_row(8'($urandom()), i == n - 1 || $urandom_range(0, 7) == 0));
      counted_items += n;
      return;
    end
    frames = $urandom_range(1, 6);
    for (int i = 0; i < frames; i++)
      add_frame(frame_kind_t'($urandom_range(0, 3)));
    if (r < 25) begin
      keep = $urandom_range(1, phrase_bits.size());
      while (phrase_bits.size() > keep)
        void'(phrase_bits.pop_back());
      n = 0;
    end else begin
      add_bits(lfbu_pkg::STOP_ENERGY, 4);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    end
    counted_items += (phrase_bits.size() + 7) / 8 + n;
    send_phrase(n);
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    lpc_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("Result transaction with no expectation waiting: tdata %h, tuser %b",
               out_tdata, out_tuser);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        compare_field("result_kind", e.kind, out_tuser);
        compare_field("field_index", e.idx, out_tdata[3:0]);
        compare_field("field_value", e.val, out_tdata[9:4]);
        compare_field("frame_end", e.fend, out_tdata[10]);
        compare_field("frame_type", e.ftype, out_tdata[13:11]);
        compare_field("phrase_status", e.status, out_tdata[14]);
        compare_field("bytes_after_stop", e.after_stop, out_tdata[22:15]);
        compare_field("last_result", e.lastr, out_tlast);
        results_checked++;
        if (e.fend)
          frame_ends++;
        if (e.kind == lfbu_pkg::KIND_SUMMARY)
          summaries++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction.", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : ready_pattern
    int  r;
    int  len;
    logic level;
    out_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        level = 1'b1;
        len   = $urandom_range(1, 8);
      end else if (r < 60) begin
        level = 1'b1;
        len   = $urandom_range(30, 80);
      end else if (r < 92) begin
        level = 1'b0;
        len   = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        len   = $urandom_range(10, 40);
      end
      repeat (len) @(negedge clk) out_tready <= level;
    end
  end

  initial begin : main_flow
    lpc_result_t none;
    none            = '0;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tlast        = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    frame_ends      = 0;
    summaries       = 0;
    bytes_sent      = 0;
    phrases_sent    = 0;
    counted_items   = 0;
    idle_cycles     = 0;
    steady_left     = 0;
    clear_state();

    stim_table.push_back(typed_row(8'hFF, 1'b1, 2,
                                   fld(lfbu_pkg::FIELD_ENERGY, 6'd15, 1'b1,
                                       lfbu_pkg::FTYPE_STOP),
                                   summ(lfbu_pkg::STATUS_STOP_FOUND, 8'd0), none, none));
    stim_table.push_back(typed_row(8'h00, 1'b1, 3,
                                   fld(lfbu_pkg::FIELD_ENERGY, lfbu_pkg::SILENT_ENERGY, 1'b1,
                                       lfbu_pkg::FTYPE_SILENT),
                                   fld(lfbu_pkg::FIELD_ENERGY, lfbu_pkg::SILENT_ENERGY, 1'b1,
                                       lfbu_pkg::FTYPE_SILENT),
                                   summ(lfbu_pkg::STATUS_NO_STOP, 8'd0), none));
    stim_table.push_back(typed_row(8'hF0, 1'b0, 1,
                                   fld(lfbu_pkg::FIELD_ENERGY, 6'd15, 1'b1,
                                       lfbu_pkg::FTYPE_STOP),
                                   none, none, none));
    stim_table.push_back(typed_row(8'h00, 1'b0, 0, none, none, none, none));
    stim_table.push_back(typed_row(8'hAA, 1'b1, 1, summ(lfbu_pkg::STATUS_STOP_FOUND, 8'd2),
                                   none, none, none));
    stim_table.push_back(typed_row(8'h0F, 1'b0, 2,
                                   fld(lfbu_pkg::FIELD_ENERGY, lfbu_pkg::SILENT_ENERGY, 1'b1,
                                       lfbu_pkg::FTYPE_SILENT),
                                   fld(lfbu_pkg::FIELD_ENERGY, 6'd15, 1'b1,
                                       lfbu_pkg::FTYPE_STOP),
                                   none, none));
    stim_table.push_back(typed_row(8'h55, 1'b1, 1, summ(lfbu_pkg::STATUS_STOP_FOUND, 8'd1),
                                   none, none, none));
    // Voiced frame with every field at its maximum, then a stop.
    stim_table.push_back(plain_row(8'hE7, 1'b0));
    for (int i = 0; i < 5; i++)
      stim_table.push_back(plain_row(8'hFF, 1'b0));
    stim_table.push_back(plain_row(8'hFC, 1'b1));
    // Unvoiced, repeat and silent frames, then a phrase end with no stop.
    stim_table.push_back(plain_row(8'h10, 1'b0));
    stim_table.push_back(plain_row(8'h1F, 1'b0));
    stim_table.push_back(plain_row(8'h07, 1'b0));
    stim_table.push_back(plain_row(8'h82, 1'b0));
    stim_table.push_back(plain_row(8'hC0, 1'b0));
    stim_table.push_back(plain_row(8'h01, 1'b1));
    // The phrase ends part way through the pitch field, which is dropped.
    stim_table.push_back(plain_row(8'h38, 1'b1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_table[i])
      send_byte(stim_table[i]);

    // A long tail after the stop drives the trailing byte count to saturation.
    phrase_bits.delete();
    add_frame(FRAME_VOICED);
    add_bits(lfbu_pkg::STOP_ENERGY, 4);
    send_phrase(TRAILER_RUN);

    while (counted_items < RANDOM_ITEMS)
      random_phrase();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d speech bytes in %0d phrases, with one tail long enough to saturate.",
             bytes_sent, phrases_sent);
    $display("Checked %0d results, of which %0d frame ends and %0d phrase summaries.",
             results_checked, frame_ends, summaries);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lfbu_pkg.sv
rtl/core/lfbu_front.sv
rtl/core/lfbu_queue.sv
rtl/core/lfbu_back.sv
rtl/core/lpc_frame_bit_unpacker_unit.sv
test/tb_lpc_frame_bit_unpacker_unit.sv
